[rtl/wrs_pkg.sv]
// Shared types and constants for the wake recovery sequencer.
// No dependencies; used by wrs_cfg, wrs_step and wake_recovery_sequencer.

package wrs_pkg;

    // Item kinds carried on the input tuser bit
    localparam logic OP_BEGIN = 1'b0;
    localparam logic OP_POLL  = 1'b1;

    // Wake causes
    localparam logic [2:0] CAUSE_COLD    = 3'd0;
    localparam logic [2:0] CAUSE_VOICE   = 3'd2;
    localparam logic [2:0] CAUSE_MSOURCE = 3'd6;
    localparam logic [2:0] CAUSE_UNKNOWN = 3'd7;

    // Actions reported in the result
    localparam logic [2:0] ACT_NONE      = 3'd0;
    localparam logic [2:0] ACT_INDICATOR = 3'd1;
    localparam logic [2:0] ACT_RESTORE   = 3'd2;
    localparam logic [2:0] ACT_NETWORK   = 3'd3;
    localparam logic [2:0] ACT_SYNC      = 3'd4;
    localparam logic [2:0] ACT_BUTTON    = 3'd5;
    localparam logic [2:0] ACT_REARM     = 3'd6;
    localparam logic [2:0] ACT_PROMPT    = 3'd7;

    // Configuration register indexes
    localparam logic [1:0] REG_RETRY_INTERVAL  = 2'd0;
    localparam logic [1:0] REG_RELEASE_DEBOUNCE = 2'd1;
    localparam logic [1:0] REG_MAX_ATTEMPTS    = 2'd2;
    localparam logic [1:0] REG_PROMPT_ON_BTN   = 2'd3;

    localparam int CFG_DATA_W  = 31;
    localparam int CFG_INDEX_W = 2;

    // Register values after reset
    localparam logic [30:0] RETRY_INTERVAL_RST   = 31'd1000;
    localparam logic [30:0] RELEASE_DEBOUNCE_RST = 31'd50;
    localparam logic [15:0] MAX_ATTEMPTS_RST     = 16'd3;
    localparam logic        PROMPT_ON_BTN_RST    = 1'b0;

    localparam logic [15:0] FAIL_COUNT_MAX = 16'hFFFF;

    // Recovery stages
    typedef enum logic [3:0] {
        ST_IDLE      = 4'd0,
        ST_INDICATOR = 4'd1,
        ST_RESTORE   = 4'd2,
        ST_NETWORK   = 4'd3,
        ST_SYNC      = 4'd4,
        ST_RELEASE   = 4'd5,
        ST_REARM     = 4'd6,
        ST_PROMPT    = 4'd7,
        ST_READY     = 4'd8,
        ST_FAULT     = 4'd9
    } stage_t;

    typedef struct packed {
        logic [30:0] retry_gap_ms;
        logic [30:0] settle_ms;
        logic [15:0] max_attempts;
        logic        prompt_on_press;
    } cfg_t;

    typedef struct packed {
        logic        op;
        logic [2:0]  cause;
        logic [31:0] now_ms;
        logic        action_ok;
        logic        buttons_released;
    } item_t;

    typedef struct packed {
        stage_t      stage;
        logic        press_wake;
        logic        want_prompt;
        logic [15:0] fail_count;
        logic        tried_before;
        logic [31:0] last_try_ms;
        logic        release_pending;
        logic [31:0] release_start_ms;
    } seq_state_t;

    typedef struct packed {
        logic        begin_ok;
        logic [3:0]  stage_now;
        logic [2:0]  action;
        logic        attempted;
        logic        action_failed;
        logic        transition;
    } result_t;

endpackage

[rtl/wake_recovery_sequencer.sv]
// Top level of the wake recovery sequencer: input register, stage update, result register.
// Depends on wrs_pkg, wrs_cfg and wrs_step.

// Each input transaction is one begin (tuser 0) or one poll tick (tuser 1) and
// produces exactly one result transaction. The block takes one transaction per
// clock cycle unless the result is stalled: a transaction lands in the input
// register, and once the result register can take it the combinational stage
// update (one 32-bit wrapping elapsed-time compare per timer, the failure
// counter and the stage select) writes the sequencer state and the result
// register together. A stalled result holds the input register; while the result
// register is free the input side keeps accepting every cycle.
// Configuration writes take effect on the next clock edge and are meant to be
// issued only while no transaction is in flight.

module wake_recovery_sequencer
(
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               cfg_we,
    input  logic [wrs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [wrs_pkg::CFG_DATA_W-1:0]     cfg_data,

    input  logic                               s_tvalid,
    output logic                               s_tready,
    // tdata from bit 0: cause[2:0], now_ms[34:3], action_ok[35],
    // buttons_released[36], zero fill[39:37]
    input  logic [39:0]                        s_tdata,
    // tuser: op (0 begin, 1 poll tick)
    input  logic                               s_tuser,

    output logic                               m_tvalid,
    input  logic                               m_tready,
    // tdata from bit 0: begin_ok[0], stage_now[4:1], action[7:5], attempted[8],
    // action_failed[9], transition[10], zero fill[15:11]
    output logic [15:0]                        m_tdata
);

    wrs_pkg::cfg_t       cfg;
    wrs_pkg::item_t      item_in;
    wrs_pkg::item_t      item_reg;
    logic                in_valid_reg;
    logic                in_valid_next;
    wrs_pkg::seq_state_t st_reg;
    wrs_pkg::seq_state_t st_next;
    wrs_pkg::result_t    res_comb;
    wrs_pkg::result_t    res_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                advance;
    logic                in_take;

    wrs_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Unpack the input transaction
    assign item_in.op               = s_tuser;
    assign item_in.cause            = s_tdata[2:0];
    assign item_in.now_ms           = s_tdata[34:3];
    assign item_in.action_ok        = s_tdata[35];
    assign item_in.buttons_released = s_tdata[36];

    // Advance the held item once the result register can take its result
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    assign in_valid_next  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    wrs_step u_step
    (
        .cfg     (cfg),
        .item    (item_reg),
        .st      (st_reg),
        .st_next (st_next),
        .res     (res_comb)
    );

    // Handshake control and sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                st_reg <= st_next;
            end
        end
    end

    // Hold the payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg <= item_in;
        end
        if (advance)
        begin
            res_reg <= res_comb;
        end
    end

    // Pack the result transaction
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b00000, res_reg.transition, res_reg.action_failed, res_reg.attempted,
                       res_reg.action, res_reg.stage_now, res_reg.begin_ok};

endmodule

[rtl/wrs_cfg.sv]
// Configuration register file of the wake recovery sequencer.
// Depends on wrs_pkg for the register indexes, reset values and cfg_t.

module wrs_cfg
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [wrs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [wrs_pkg::CFG_DATA_W-1:0]     cfg_data,
    output wrs_pkg::cfg_t                      cfg
);

    wrs_pkg::cfg_t cfg_reg;
    wrs_pkg::cfg_t cfg_next;

    // Decode the write into the selected register
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                wrs_pkg::REG_RETRY_INTERVAL:   cfg_next.retry_gap_ms = cfg_data;
                wrs_pkg::REG_RELEASE_DEBOUNCE: cfg_next.settle_ms = cfg_data;
                wrs_pkg::REG_MAX_ATTEMPTS:     cfg_next.max_attempts = cfg_data[15:0];
                wrs_pkg::REG_PROMPT_ON_BTN:    cfg_next.prompt_on_press = cfg_data[0];
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.retry_gap_ms    <= wrs_pkg::RETRY_INTERVAL_RST;
            cfg_reg.settle_ms       <= wrs_pkg::RELEASE_DEBOUNCE_RST;
            cfg_reg.max_attempts    <= wrs_pkg::MAX_ATTEMPTS_RST;
            cfg_reg.prompt_on_press <= wrs_pkg::PROMPT_ON_BTN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/wrs_step.sv]
// Stage update logic: one begin or poll item against the current sequencer state.
// Purely combinational; depends on wrs_pkg for types, stages and action codes.

module wrs_step
(
    input  wrs_pkg::cfg_t       cfg,
    input  wrs_pkg::item_t      item,
    input  wrs_pkg::seq_state_t st,
    output wrs_pkg::seq_state_t st_next,
    output wrs_pkg::result_t    res
);

    logic [31:0]     try_elapsed;
    logic [31:0]     release_elapsed;
    logic            due;
    logic            released_long;
    logic            cfg_valid;
    logic            is_button;
    logic            can_begin;
    logic [15:0]     fail_inc;
    logic [2:0]      stage_action;
    wrs_pkg::stage_t success_stage;

    // Wrapping elapsed times, compared unsigned against the intervals
    assign try_elapsed     = item.now_ms - st.last_try_ms;
    assign release_elapsed = item.now_ms - st.release_start_ms;
    assign due = !st.tried_before || (try_elapsed >= {1'b0, cfg.retry_gap_ms});
    assign released_long = release_elapsed >= {1'b0, cfg.settle_ms};

    assign cfg_valid = (cfg.retry_gap_ms != '0) && (cfg.settle_ms != '0)
                       && (cfg.max_attempts != '0);
    assign is_button = (item.cause >= wrs_pkg::CAUSE_VOICE)
                       && (item.cause <= wrs_pkg::CAUSE_MSOURCE);
    assign can_begin = (st.stage == wrs_pkg::ST_IDLE) || (st.stage == wrs_pkg::ST_READY)
                       || (st.stage == wrs_pkg::ST_FAULT);

    // Saturating failure count
    assign fail_inc = (st.fail_count == wrs_pkg::FAIL_COUNT_MAX) ? st.fail_count
                                                                 : st.fail_count + 16'd1;

    // Action code and successor of each retried stage
    always_comb
    begin
        stage_action  = wrs_pkg::ACT_NONE;
        success_stage = st.stage;
        unique case (st.stage)
            wrs_pkg::ST_INDICATOR:
            begin
                stage_action  = wrs_pkg::ACT_INDICATOR;
                success_stage = wrs_pkg::ST_RESTORE;
            end
            wrs_pkg::ST_RESTORE:
            begin
                stage_action  = wrs_pkg::ACT_RESTORE;
                success_stage = wrs_pkg::ST_NETWORK;
            end
            wrs_pkg::ST_NETWORK:
            begin
                stage_action  = wrs_pkg::ACT_NETWORK;
                success_stage = wrs_pkg::ST_SYNC;
            end
            wrs_pkg::ST_SYNC:
            begin
                stage_action  = wrs_pkg::ACT_SYNC;
                success_stage = st.press_wake ? wrs_pkg::ST_RELEASE : wrs_pkg::ST_REARM;
            end
            wrs_pkg::ST_REARM:
            begin
                stage_action  = wrs_pkg::ACT_REARM;
                success_stage = st.want_prompt ? wrs_pkg::ST_PROMPT : wrs_pkg::ST_READY;
            end
            default:
            begin
                stage_action  = wrs_pkg::ACT_NONE;
                success_stage = st.stage;
            end
        endcase
    end

    // Next state and result
    always_comb
    begin
        st_next = st;
        res     = '0;
        if (item.op == wrs_pkg::OP_BEGIN)
        begin
            if (can_begin)
            begin
                st_next.press_wake      = is_button;
                st_next.want_prompt     = is_button && cfg.prompt_on_press;
                st_next.fail_count      = '0;
                st_next.tried_before    = 1'b0;
                st_next.release_pending = 1'b0;
                if (!cfg_valid || (item.cause == wrs_pkg::CAUSE_COLD)
                    || (item.cause == wrs_pkg::CAUSE_UNKNOWN))
                begin
                    st_next.stage = wrs_pkg::ST_FAULT;
                end
                else
                begin
                    st_next.stage = is_button ? wrs_pkg::ST_INDICATOR : wrs_pkg::ST_RESTORE;
                    res.begin_ok  = 1'b1;
                end
            end
        end
        else
        begin
            unique case (st.stage)
                wrs_pkg::ST_INDICATOR, wrs_pkg::ST_RESTORE, wrs_pkg::ST_NETWORK,
                wrs_pkg::ST_SYNC, wrs_pkg::ST_REARM:
                begin
                    if (due)
                    begin
                        res.action           = stage_action;
                        res.attempted        = 1'b1;
                        st_next.tried_before = 1'b1;
                        st_next.last_try_ms  = item.now_ms;
                        if (item.action_ok)
                        begin
                            st_next.stage        = success_stage;
                            st_next.fail_count   = '0;
                            st_next.tried_before = 1'b0;
                            res.transition       = 1'b1;
                        end
                        else
                        begin
                            res.action_failed  = 1'b1;
                            st_next.fail_count = fail_inc;
                            if (fail_inc >= cfg.max_attempts)
                            begin
                                st_next.stage        = wrs_pkg::ST_FAULT;
                                st_next.fail_count   = '0;
                                st_next.tried_before = 1'b0;
                                res.transition       = 1'b1;
                            end
                        end
                    end
                end
                wrs_pkg::ST_RELEASE:
                begin
                    res.attempted = 1'b1;
                    res.action    = wrs_pkg::ACT_BUTTON;
                    if (!item.buttons_released)
                    begin
                        st_next.release_pending = 1'b0;
                    end
                    else if (!st.release_pending)
                    begin
                        st_next.release_pending  = 1'b1;
                        st_next.release_start_ms = item.now_ms;
                    end
                    else if (released_long)
                    begin
                        st_next.stage        = wrs_pkg::ST_REARM;
                        st_next.fail_count   = '0;
                        st_next.tried_before = 1'b0;
                        res.transition       = 1'b1;
                    end
                end
                wrs_pkg::ST_PROMPT:
                begin
                    res.attempted        = 1'b1;
                    res.action           = wrs_pkg::ACT_PROMPT;
                    st_next.stage        = wrs_pkg::ST_READY;
                    st_next.fail_count   = '0;
                    st_next.tried_before = 1'b0;
                    res.transition       = 1'b1;
                end
                default:
                begin
                    st_next = st;
                end
            endcase
        end
        res.stage_now = st_next.stage;
    end

endmodule
